>>> sv/trsp_pkg.sv
// ----------------------------------------------------------------------------
// trsp_pkg
// Shared types, character codes and status codes of the time range stamp
// parser.
// ----------------------------------------------------------------------------
package trsp_pkg;

   localparam int CH_W     = 8;
   localparam int STATUS_W = 2;
   localparam int MS_W     = 36;
   localparam int OFFSET_W = 13;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVER = 2'd2;

   localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
   localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CH_W-1:0] CH_DASH  = 8'h2D;
   localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CH_W-1:0] CH_VT    = 8'h0B;
   localparam logic [CH_W-1:0] CH_FF    = 8'h0C;
   localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

   localparam logic [15:0] MS_PER_MIN = 16'd60000;
   localparam logic [15:0] MS_PER_SEC = 16'd1000;

   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            line_start;
      logic            is_end;
   } item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [MS_W-1:0]     from_ms;
      logic [MS_W-1:0]     to_ms;
      logic [OFFSET_W-1:0] text_offset;
   } result_type;

   function automatic logic is_blank(input logic [CH_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
             (c == CH_VT) || (c == CH_FF);
   endfunction

   function automatic logic is_digit(input logic [CH_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

endpackage

>>> sv/trsp_core.sv
// ----------------------------------------------------------------------------
// trsp_core
// Parser state and the per-character update; time sums are built up as each
// field closes so the final tab needs one add.
// ----------------------------------------------------------------------------
module trsp_core #(
   parameter int DIGIT_LIMIT = 6,
   parameter int LINE_MAX    = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  trsp_pkg::item_type     item,
   output logic                   emit,
   output trsp_pkg::result_type   result
);
   import trsp_pkg::*;

   localparam int ACC_W = $clog2(10**DIGIT_LIMIT);
   localparam int CNT_W = $clog2(DIGIT_LIMIT + 2);
   localparam int POS_W = $clog2(LINE_MAX + 1);

   localparam logic [3:0] PH_LEAD     = 4'd0;
   localparam logic [3:0] PH_FA       = 4'd1;
   localparam logic [3:0] PH_FS_NEED  = 4'd2;
   localparam logic [3:0] PH_FS       = 4'd3;
   localparam logic [3:0] PH_FMS_NEED = 4'd4;
   localparam logic [3:0] PH_FMS      = 4'd5;
   localparam logic [3:0] PH_TA_NEED  = 4'd6;
   localparam logic [3:0] PH_TA       = 4'd7;
   localparam logic [3:0] PH_TS_NEED  = 4'd8;
   localparam logic [3:0] PH_TS       = 4'd9;
   localparam logic [3:0] PH_TMS_NEED = 4'd10;
   localparam logic [3:0] PH_TMS      = 4'd11;

   logic [3:0]       phase_ff, phase_in, e_phase;
   logic             skip_ff, skip_in, e_skip;
   logic [ACC_W-1:0] acc_ff, acc_in, e_acc;
   logic [CNT_W-1:0] cnt_ff, cnt_in, e_cnt, cnt_inc;
   logic [MS_W-1:0]  from_ff, from_in, e_from;
   logic [MS_W-1:0]  to_ff, to_in, e_to;
   logic [POS_W-1:0] pos_ff, pos_in, e_pos, pos_inc;
   logic             fin_ff, fin_in, e_fin;

   logic [CH_W-1:0]    c;
   logic [3:0]         digit;
   logic [ACC_W+3:0]   acc_x10;
   logic               use_min;
   logic [MS_W-1:0]    scaled;
   logic [MS_W-1:0]    acc_ext;
   logic               term;

   always_comb begin
      c       = item.ch;
      digit   = 4'(c - CH_ZERO);
      e_phase = item.line_start ? PH_LEAD : phase_ff;
      e_skip  = item.line_start ? 1'b0 : skip_ff;
      e_acc   = item.line_start ? '0 : acc_ff;
      e_cnt   = item.line_start ? '0 : cnt_ff;
      e_from  = item.line_start ? '0 : from_ff;
      e_to    = item.line_start ? '0 : to_ff;
      e_pos   = item.line_start ? '0 : pos_ff;
      e_fin   = item.line_start ? 1'b0 : fin_ff;
      cnt_inc = e_cnt + CNT_W'(1);
      pos_inc = e_pos + POS_W'(1);
      acc_x10 = ({4'd0, e_acc} << 3) + ({4'd0, e_acc} << 1) + (ACC_W+4)'(digit);
      acc_ext = MS_W'(e_acc);
      use_min = (c == CH_COLON);
      scaled  = MS_W'(acc_ext * MS_W'(use_min ? MS_PER_MIN : MS_PER_SEC));

      case (e_phase)
         PH_FA, PH_TA: term = (c == CH_COLON) || (c == CH_DOT);
         PH_FS, PH_TS: term = (c == CH_DOT);
         PH_FMS:       term = (c == CH_DASH);
         PH_TMS:       term = (c == CH_TAB);
         default:      term = 1'b0;
      endcase

      phase_in = e_phase;
      skip_in  = e_skip;
      acc_in   = e_acc;
      cnt_in   = e_cnt;
      from_in  = e_from;
      to_in    = e_to;
      pos_in   = e_pos;
      fin_in   = e_fin;
      emit     = 1'b0;
      result   = '0;

      if (!e_fin) begin
         if (item.is_end || (e_pos >= POS_W'(LINE_MAX))) begin
            emit          = 1'b1;
            result.status = ST_BAD;
         end else begin
            pos_in = pos_inc;
            case (e_phase)
               PH_LEAD, PH_FS_NEED, PH_FMS_NEED, PH_TA_NEED, PH_TS_NEED,
               PH_TMS_NEED: begin
                  if ((e_phase == PH_LEAD) && is_blank(c)) begin
                     phase_in = e_phase;
                  end else if (!is_digit(c)) begin
                     emit          = 1'b1;
                     result.status = ST_BAD;
                  end else begin
                     acc_in   = ACC_W'(digit);
                     cnt_in   = CNT_W'(1);
                     skip_in  = 1'b0;
                     phase_in = e_phase + 4'd1;
                  end
               end
               PH_FA, PH_FS, PH_FMS, PH_TA, PH_TS, PH_TMS: begin
                  if (!term) begin
                     if (e_skip) begin
                        skip_in = 1'b1;
                     end else if (!is_digit(c)) begin
                        skip_in = 1'b1;
                     end else if (cnt_inc > CNT_W'(DIGIT_LIMIT)) begin
                        emit          = 1'b1;
                        result.status = ST_OVER;
                     end else begin
                        cnt_in = cnt_inc;
                        acc_in = ACC_W'(acc_x10);
                     end
                  end else begin
                     case (e_phase)
                        PH_FA: begin
                           from_in  = scaled;
                           phase_in = use_min ? PH_FS_NEED : PH_FMS_NEED;
                        end
                        PH_FS: begin
                           from_in  = e_from + scaled;
                           phase_in = PH_FMS_NEED;
                        end
                        PH_FMS: begin
                           from_in  = e_from + acc_ext;
                           phase_in = PH_TA_NEED;
                        end
                        PH_TA: begin
                           to_in    = scaled;
                           phase_in = use_min ? PH_TS_NEED : PH_TMS_NEED;
                        end
                        PH_TS: begin
                           to_in    = e_to + scaled;
                           phase_in = PH_TMS_NEED;
                        end
                        default: begin
                           emit               = 1'b1;
                           result.status      = ST_OK;
                           result.from_ms     = e_from;
                           result.to_ms       = e_to + acc_ext;
                           result.text_offset = OFFSET_W'(pos_inc);
                        end
                     endcase
                  end
               end
               default: begin
                  emit          = 1'b1;
                  result.status = ST_BAD;
               end
            endcase
         end
         if (emit) begin
            fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         skip_ff  <= 1'b0;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         from_ff  <= '0;
         to_ff    <= '0;
         pos_ff   <= '0;
         fin_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         from_ff  <= from_in;
         to_ff    <= to_in;
         pos_ff   <= pos_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

>>> sv/time_range_stamp_parser.sv
// ----------------------------------------------------------------------------
// time_range_stamp_parser
// Parses a leading "[M:]S.MS-[M:]S.MS<tab>" time range from a character
// stream and reports both times in milliseconds.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one character item per handshake (req_valid/req_ready),
//   with req_line_start marking the first character of a line and req_is_end
//   marking the terminator. rsp_* carries at most one result per line
//   (rsp_valid/rsp_ready): status, from_ms, to_ms and text_offset.
//   An accepted item is held in the input register and processed against the
//   parser state when the output register is empty or being read; any result
//   is loaded into the output register at that edge, which raises rsp_valid.
//   Throughput is one item per cycle unless an unread result stalls it; the
//   per-character update, one constant multiply and one add, sets the cycle.
//   Reset clears the parser to the line start state; no line_start is needed
//   for the first line.
//   While rsp_valid is high and rsp_ready is low the held item waits, so
//   req_ready drops once the input register is also full; nothing is lost.
// ----------------------------------------------------------------------------
module time_range_stamp_parser #(
   parameter int DIGIT_LIMIT = 6,
   parameter int LINE_MAX    = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [trsp_pkg::CH_W-1:0]          req_ch,
   input  logic                               req_line_start,
   input  logic                               req_is_end,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [trsp_pkg::STATUS_W-1:0]      rsp_status,
   output logic [trsp_pkg::MS_W-1:0]          rsp_from_ms,
   output logic [trsp_pkg::MS_W-1:0]          rsp_to_ms,
   output logic [trsp_pkg::OFFSET_W-1:0]      rsp_text_offset
);
   import trsp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       advance;
   logic       emit;
   result_type result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   trsp_core #(
      .DIGIT_LIMIT (DIGIT_LIMIT),
      .LINE_MAX    (LINE_MAX)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .emit   (emit),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.ch         <= req_ch;
         item_ff.line_start <= req_line_start;
         item_ff.is_end     <= req_is_end;
      end
      if (advance && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_from_ms     = out_ff.from_ms;
   assign rsp_to_ms       = out_ff.to_ms;
   assign rsp_text_offset = out_ff.text_offset;

endmodule

>>> sim/time_range_stamp_parser_tb.sv
// ----------------------------------------------------------------------------
// time_range_stamp_parser_tb
// Streams text lines into the stamp parser one character item at a time.
// The lines are a short directed set and random lines that are mostly
// well-formed stamps with random numbers, skipped text and trailing text,
// plus truncated lines, corrupted lines and noise. A behavioral parser
// predicts each result, and every result from the block is checked field
// by field. Both handshakes idle at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module time_range_stamp_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import trsp_pkg::*;

   localparam int DIGIT_LIMIT = 6;
   localparam int LINE_MAX    = 4096;
   localparam int ITEM_GOAL   = 1700;
   localparam int IDLE_LIMIT  = 2000;
   localparam int IDLE_PCT    = 12;

   typedef enum logic [3:0] {
      P_LEAD, P_FA, P_FS_NEED, P_FS, P_FMS_NEED, P_FMS,
      P_TA_NEED, P_TA, P_TS_NEED, P_TS, P_TMS_NEED, P_TMS
   } parse_phase_type;

   class stamp_tracker_type;
      parse_phase_type ph;
      bit              skipping;
      logic [19:0]     acc;
      int              ndig;
      logic [19:0]     s_min, s_sec, s_ms, e_min, e_sec;
      int              pos;
      bit              done;
      result_type      stamps_due[$];
      int              mismatches;

      function new();
         clear();
         mismatches = 0;
      endfunction

      function void clear();
         ph       = P_LEAD;
         skipping = 1'b0;
         acc      = '0;
         ndig     = 0;
         s_min    = '0;
         s_sec    = '0;
         s_ms     = '0;
         e_min    = '0;
         e_sec    = '0;
         pos      = 0;
         done     = 1'b0;
      endfunction

      function bit is_numeral(logic [CH_W-1:0] c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      function bit is_space_char(logic [CH_W-1:0] c);
         return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
                c == CH_VT || c == CH_FF;
      endfunction

      function void queue_stamp(logic [STATUS_W-1:0] st, logic [MS_W-1:0] from_v,
                                logic [MS_W-1:0] to_v, logic [OFFSET_W-1:0] off);
         stamps_due.push_back(result_type'{st, from_v, to_v, off});
         done = 1'b1;
      endfunction

      function void start_number(logic [CH_W-1:0] c);
         acc      = 20'(c - CH_ZERO);
         ndig     = 1;
         skipping = 1'b0;
      endfunction

      function void note_char(item_type it);
         logic [CH_W-1:0] c;
         bit              delim;
         logic [MS_W-1:0] from_v, to_v;
         c = it.ch;
         if (it.line_start)
            clear();
         if (done)
            return;
         if (it.is_end || pos >= LINE_MAX) begin
            queue_stamp(ST_BAD, '0, '0, '0);
            return;
         end
         pos++;
         case (ph)
            P_LEAD: begin
               if (is_space_char(c))
                  return;
               if (!is_numeral(c)) begin
                  queue_stamp(ST_BAD, '0, '0, '0);
                  return;
               end
               start_number(c);
               ph = P_FA;
               return;
            end
            P_FS_NEED, P_FMS_NEED, P_TA_NEED, P_TS_NEED, P_TMS_NEED: begin
               if (!is_numeral(c)) begin
                  queue_stamp(ST_BAD, '0, '0, '0);
                  return;
               end
               start_number(c);
               ph = parse_phase_type'(ph + 1);
               return;
            end
            default: ;
         endcase
         case (ph)
            P_FA, P_TA: delim = (c == CH_COLON) || (c == CH_DOT);
            P_FS, P_TS: delim = (c == CH_DOT);
            P_FMS:      delim = (c == CH_DASH);
            default:    delim = (c == CH_TAB);
         endcase
         if (!delim) begin
            if (!skipping) begin
               if (!is_numeral(c)) begin
                  skipping = 1'b1;
               end else begin
                  ndig++;
                  if (ndig > DIGIT_LIMIT)
                     queue_stamp(ST_OVER, '0, '0, '0);
                  else
                     acc = acc * 10 + 20'(c - CH_ZERO);
               end
            end
            return;
         end
         case (ph)
            P_FA: begin
               if (c == CH_COLON) begin
                  s_min = acc;
                  ph    = P_FS_NEED;
               end else begin
                  s_min = '0;
                  s_sec = acc;
                  ph    = P_FMS_NEED;
               end
            end
            P_FS: begin
               s_sec = acc;
               ph    = P_FMS_NEED;
            end
            P_FMS: begin
               s_ms = acc;
               ph   = P_TA_NEED;
            end
            P_TA: begin
               if (c == CH_COLON) begin
                  e_min = acc;
                  ph    = P_TS_NEED;
               end else begin
                  e_min = '0;
                  e_sec = acc;
                  ph    = P_TMS_NEED;
               end
            end
            P_TS: begin
               e_sec = acc;
               ph    = P_TMS_NEED;
            end
            default: begin
               from_v = 36'(s_ms) + 36'(s_sec) * MS_PER_SEC + 36'(s_min) * MS_PER_MIN;
               to_v   = 36'(acc) + 36'(e_sec) * MS_PER_SEC + 36'(e_min) * MS_PER_MIN;
               queue_stamp(ST_OK, from_v, to_v, OFFSET_W'(pos));
            end
         endcase
      endfunction

      function void compare_field(string name, logic [MS_W-1:0] want, logic [MS_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_stamp(result_type got);
         result_type want;
         if (stamps_due.size() == 0) begin
            $display("%0t: unexpected result, status %0d from %0d to %0d offset %0d",
                     $time, got.status, got.from_ms, got.to_ms, got.text_offset);
            mismatches++;
            return;
         end
         want = stamps_due.pop_front();
         compare_field("status", MS_W'(want.status), MS_W'(got.status));
         compare_field("from_ms", want.from_ms, got.from_ms);
         compare_field("to_ms", want.to_ms, got.to_ms);
         compare_field("text_offset", MS_W'(want.text_offset), MS_W'(got.text_offset));
      endfunction
   endclass

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic [CH_W-1:0]     req_ch          = '0;
   logic                req_line_start  = 1'b0;
   logic                req_is_end      = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [MS_W-1:0]     rsp_from_ms;
   logic [MS_W-1:0]     rsp_to_ms;
   logic [OFFSET_W-1:0] rsp_text_offset;

   stamp_tracker_type tracker;
   bit                req_took     = 1'b0;
   int                stall_cycles = 0;
   int                req_idle_pct = IDLE_PCT;
   int                rsp_idle_pct = IDLE_PCT;
   int                line_chars   = 0;
   logic [CH_W-1:0]   line_q[$];

   time_range_stamp_parser #(
      .DIGIT_LIMIT(DIGIT_LIMIT),
      .LINE_MAX(LINE_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_ch(req_ch),
      .req_line_start(req_line_start),
      .req_is_end(req_is_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_from_ms(rsp_from_ms),
      .rsp_to_ms(rsp_to_ms),
      .rsp_text_offset(rsp_text_offset)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         req_took     = 1'b0;
         stall_cycles = 0;
      end else begin
         req_took = req_valid && req_ready;
         if (req_took)
            tracker.note_char(item_type'{req_ch, req_line_start, req_is_end});
         if (rsp_valid && rsp_ready)
            tracker.check_stamp(result_type'{rsp_status, rsp_from_ms, rsp_to_ms,
                                             rsp_text_offset});
         if (req_took || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic send_char(logic [CH_W-1:0] c, logic ls, logic is_end);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_ch         <= c;
      req_line_start <= ls;
      req_is_end     <= is_end;
      do @(negedge clock); while (!req_took);
      line_chars++;
   endtask

   task automatic send_line(bit ls, bit end_after);
      foreach (line_q[i])
         send_char(line_q[i], ls && i == 0, 1'b0);
      if (end_after)
         send_char(CH_W'($urandom_range(255)), ls && line_q.size() == 0, 1'b1);
   endtask

   function automatic void load_text(string s);
      line_q.delete();
      foreach (s[i])
         line_q.push_back(s[i]);
   endfunction

   function automatic logic [CH_W-1:0] pick_junk(logic [CH_W-1:0] d1, logic [CH_W-1:0] d2,
                                                 bit no_digit);
      logic [CH_W-1:0] c;
      do
         c = CH_W'($urandom_range(255));
      while (c == d1 || c == d2 || (no_digit && c >= CH_ZERO && c <= CH_NINE));
      return c;
   endfunction

   function automatic logic [CH_W-1:0] pick_blank();
      case ($urandom_range(5))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_LF;
         3:       return CH_CR;
         4:       return CH_VT;
         default: return CH_FF;
      endcase
   endfunction

   function automatic void add_number(logic [CH_W-1:0] d1, logic [CH_W-1:0] d2);
      int nd;
      bit nines;
      int nj;
      case ($urandom_range(39))
         0:       nd = 0;
         1:       nd = $urandom_range(9, 7);
         default: nd = $urandom_range(6, 1);
      endcase
      nines = (nd == 6) && ($urandom_range(3) == 0);
      for (int i = 0; i < nd; i++)
         line_q.push_back(nines ? CH_NINE : CH_W'(CH_ZERO + $urandom_range(9)));
      if ($urandom_range(5) == 0) begin
         line_q.push_back(pick_junk(d1, d2, 1'b1));
         nj = $urandom_range(3);
         repeat (nj) line_q.push_back(pick_junk(d1, d2, 1'b0));
      end
   endfunction

   function automatic void add_time(logic [CH_W-1:0] ms_end);
      if ($urandom_range(1)) begin
         add_number(CH_COLON, CH_DOT);
         line_q.push_back(CH_COLON);
         add_number(CH_DOT, CH_DOT);
      end else begin
         add_number(CH_COLON, CH_DOT);
      end
      line_q.push_back(CH_DOT);
      add_number(ms_end, ms_end);
   endfunction

   function automatic void build_stamp();
      line_q.delete();
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(3, 1)) line_q.push_back(pick_blank());
      add_time(CH_DASH);
      line_q.push_back(CH_DASH);
      add_time(CH_TAB);
      line_q.push_back(CH_TAB);
   endfunction

   initial begin
      int base;
      int pick;
      int keep;
      bit end_after;
      tracker = new();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      load_text("0.0-9.9\t");
      send_line(1'b0, 1'b0);
      line_q.delete();
      send_line(1'b1, 1'b1);
      load_text("x");
      send_line(1'b1, 1'b0);
      load_text("1:.2");
      send_line(1'b1, 1'b0);
      load_text("1234567");
      send_line(1'b1, 1'b0);
      load_text(" 1");
      send_line(1'b1, 1'b1);

      base = line_chars;
      while (line_chars - base < ITEM_GOAL) begin
         if (line_chars - base >= 600 && line_chars - base < 1000) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = IDLE_PCT;
            rsp_idle_pct = IDLE_PCT;
         end
         pick      = $urandom_range(99);
         end_after = 1'b0;
         build_stamp();
         if (pick < 65) begin
            send_line(1'b1, 1'b0);
         end else if (pick < 80) begin
            keep = $urandom_range(line_q.size() - 1);
            while (line_q.size() > keep)
               void'(line_q.pop_back());
            send_line(1'b1, 1'b1);
         end else if (pick < 92) begin
            line_q[$urandom_range(line_q.size() - 1)] = CH_W'($urandom_range(255));
            send_line(1'b1, 1'b0);
         end else begin
            repeat ($urandom_range(8, 1))
               send_char(CH_W'($urandom_range(255)), $urandom_range(7) == 0,
                         $urandom_range(7) == 0);
         end
         if ($urandom_range(2) == 0)
            repeat ($urandom_range(3, 1))
               send_char(CH_W'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
      end
      req_valid <= 1'b0;

      while (tracker.stamps_due.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (tracker.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> time_range_stamp_parser.f
sv/trsp_pkg.sv
sv/trsp_core.sv
sv/time_range_stamp_parser.sv
sim/time_range_stamp_parser_tb.sv
